FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TLBS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TLBS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tlbs_pkg.sv
// Types and constants of the table search block.
`default_nettype none

package tlbs_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 8;
  localparam int KIND_W  = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/tlbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tlbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/tlbs_cmp.sv
// Shared signed 32-bit compare unit used by both search modes.
`default_nettype none

module tlbs_cmp (
  input  wire logic signed [tlbs_pkg::VALUE_W-1:0] elem_i,
  input  wire logic signed [tlbs_pkg::VALUE_W-1:0] key_i,
  output      tlbs_pkg::cmp_res_t                  res_o
);

  import tlbs_pkg::*;

  always_comb begin
    res_o.eq = (elem_i == key_i);
    res_o.gt = (elem_i > key_i);
  end

endmodule

`default_nettype wire

FILE: rtl/table_linear_binary_search.sv
// Top level of the table search block: table storage, search sequencer, result register.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_kind_i, in_item_value_i
//   out     | output    | out_valid_o / out_stall_i | out_found_o, out_position_o, out_overflowed_o
//   cfg     | input     | cfg_we_i                  | cfg_wdata_i (search_mode)
//
// Append, clear and unused words are taken in the idle state without stalling the input. A search
// probes one entry per cycle in linear mode through the RAM's registered read port; in binary mode
// each probe passes an address state and a compare state; an empty table goes to the result state.
// The input stalls while a search runs; a finished result waits in the output register.
// Reset clears the count, the overflow flag, the mode and the sequencer; the table RAM is
// not cleared. out_stall_i holds a search result until the previous one has left.
`default_nettype none

module table_linear_binary_search #(
  parameter int TABLE_DEPTH = 128
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic [tlbs_pkg::KIND_W-1:0]         in_kind_i,
  input  wire logic signed [tlbs_pkg::VALUE_W-1:0] in_item_value_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic                                out_found_o,
  output      logic [tlbs_pkg::POS_W-1:0]          out_position_o,
  output      logic                                out_overflowed_o
);

  import tlbs_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LIN  = 3'd1;
  localparam logic [2:0] ST_BIS  = 3'd2;
  localparam logic [2:0] ST_BCMP = 3'd3;
  localparam logic [2:0] ST_RES  = 3'd4;

  logic [2:0]                state_q, state_d;
  logic [CW-1:0]             count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic                      mode_q;
  logic [CW-1:0]             idx_q, idx_d;
  logic [CW-1:0]             hx_q, hx_d;
  logic [CW-1:0]             mid_q, mid_d;
  logic                      pend_q, pend_d;
  logic signed [VALUE_W-1:0] key_q, key_d;
  logic                      res_found_q, res_found_d;
  logic [CW-1:0]             res_pos_q, res_pos_d;
  logic                      res_ovf_q, res_ovf_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_found_q, out_found_d;
  logic [POS_W-1:0]          out_pos_q, out_pos_d;
  logic                      out_ovf_q, out_ovf_d;

  logic                      in_acc;
  logic                      ram_we;
  logic [AW-1:0]             ram_raddr;
  logic [VALUE_W-1:0]        ram_rdata;
  cmp_res_t                  cmp_res;
  logic [CW-1:0]             span_w;
  logic [CW-1:0]             mid_w;
  logic [CW-1:0]             lo_n;
  logic [CW-1:0]             hx_n;
  logic [CW+POS_W-1:0]       pos_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign span_w  = hx_q - idx_q - CW'(1);
  assign mid_w   = idx_q + (span_w >> 1);
  assign pos_ext = {{POS_W{1'b0}}, res_pos_q};

  tlbs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (in_item_value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tlbs_cmp u_cmp (
    .elem_i (ram_rdata),
    .key_i  (key_q),
    .res_o  (cmp_res)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    idx_d       = idx_q;
    hx_d        = hx_q;
    mid_d       = mid_q;
    pend_d      = pend_q;
    key_d       = key_q;
    res_found_d = res_found_q;
    res_pos_d   = res_pos_q;
    res_ovf_d   = res_ovf_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_pos_d   = out_pos_q;
    out_ovf_d   = out_ovf_q;
    ram_we      = 1'b0;
    ram_raddr   = '0;
    lo_n        = mid_q + CW'(1);
    hx_n        = hx_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_kind_i)
            KIND_APPEND: begin
              if (count_q < CW'(TABLE_DEPTH)) begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            KIND_SEARCH: begin
              key_d     = in_item_value_i;
              res_ovf_d = ovf_q;
              idx_d     = '0;
              hx_d      = count_q;
              pend_d    = 1'b0;
              if (count_q == '0) begin
                res_found_d = 1'b0;
                res_pos_d   = '0;
                state_d     = ST_RES;
              end else if (mode_q) begin
                state_d = ST_BIS;
              end else begin
                state_d = ST_LIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIN: begin
        ram_raddr = idx_q[AW-1:0];
        if (pend_q && cmp_res.eq) begin
          res_found_d = 1'b1;
          res_pos_d   = idx_q;
          state_d     = ST_RES;
        end else if (idx_q == count_q) begin
          res_found_d = 1'b0;
          res_pos_d   = '0;
          state_d     = ST_RES;
        end else begin
          pend_d = 1'b1;
          idx_d  = idx_q + CW'(1);
        end
      end
      ST_BIS: begin
        ram_raddr = mid_w[AW-1:0];
        mid_d     = mid_w;
        state_d   = ST_BCMP;
      end
      ST_BCMP: begin
        if (cmp_res.eq) begin
          res_found_d = 1'b1;
          res_pos_d   = mid_q + CW'(1);
          state_d     = ST_RES;
        end else begin
          if (cmp_res.gt) begin
            lo_n = idx_q;
            hx_n = mid_q;
          end
          idx_d = lo_n;
          hx_d  = hx_n;
          if (hx_n > lo_n) begin
            state_d = ST_BIS;
          end else begin
            res_found_d = 1'b0;
            res_pos_d   = '0;
            state_d     = ST_RES;
          end
        end
      end
      ST_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_pos_d   = pos_ext[POS_W-1:0];
          out_ovf_d   = res_ovf_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      mode_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    hx_q        <= hx_d;
    mid_q       <= mid_d;
    key_q       <= key_d;
    res_found_q <= res_found_d;
    res_pos_q   <= res_pos_d;
    res_ovf_q   <= res_ovf_d;
    out_found_q <= out_found_d;
    out_pos_q   <= out_pos_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_found_o      = out_found_q;
  assign out_position_o   = out_pos_q;
  assign out_overflowed_o = out_ovf_q;

endmodule

`default_nettype wire

FILE: rtl/tlbs_checker.sv
// Port-level checker for the table search block and its bind.
`default_nettype none
`include "assert_macros.svh"

module tlbs_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic [tlbs_pkg::KIND_W-1:0]         in_kind_i,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic                                out_found_o,
  input wire logic [tlbs_pkg::POS_W-1:0]          out_position_o
);

  import tlbs_pkg::*;

  logic search_acc;

  assign search_acc = in_valid_i && !in_stall_o && (in_kind_i == KIND_SEARCH);

  `TLBS_ASSERT_ALWAYS(a_reset_no_valid, clk_i, !rst_ni |-> !out_valid_o, "result word during reset")

  `TLBS_ASSERT(a_search_stalls, clk_i, rst_ni, search_acc |=> in_stall_o, "input not stalled while search runs")

  `TLBS_ASSERT(a_miss_pos_zero, clk_i, rst_ni, out_valid_o && !out_found_o |-> out_position_o == '0, "miss word carries a position")

  `TLBS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_position_o) && $stable(out_found_o), "stalled result word changed")

endmodule

bind table_linear_binary_search tlbs_checker u_tlbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_kind_i      (in_kind_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_found_o    (out_found_o),
  .out_position_o (out_position_o)
);

`default_nettype wire
